// ===== src/assert_macros.svh =====
// Assertion macros shared by the trial-division prime test RTL.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Invariant checked at every clock edge outside reset.
`define TDPT_ASSERT(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Condition in one cycle implies a condition in the next.
`define TDPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/tdpt_pkg.sv =====
// Package for the trial-division prime test: default width, FSM state type,
// and the structs passed between controller, remainder unit and top level.
package tdpt_pkg;

  // Default width of the tested value
  localparam int VALUE_BITS_DEF = 32;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } tdpt_state_t;

  // Remainder unit status
  typedef struct packed {
    logic done;
    logic zero;
  } rem_status_t;

  // Result handed from controller to the output register
  typedef struct packed {
    logic valid;
    logic not_positive;
    logic is_prime;
  } result_t;

endpackage

// ===== src/tdpt_rem.sv =====
// Bit-serial restoring remainder unit: dividend % divisor, one dividend bit
// per cycle, MSB first. Depends on tdpt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tdpt_rem import tdpt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [VALUE_BITS-1:0] divisor,
  output rem_status_t           status
);

  localparam int CW = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] LAST_CNT = CW'(VALUE_BITS - 1);

  logic                  busy;
  logic                  done;
  logic [CW-1:0]         cnt;
  logic [VALUE_BITS-1:0] shreg;
  logic [VALUE_BITS-1:0] dvs;
  logic [VALUE_BITS-1:0] rem;

  logic [VALUE_BITS-1:0] trial;
  logic [VALUE_BITS-1:0] rem_next;

  // One restoring step: bring in the next dividend bit, subtract if it fits.
  // The partial remainder stays below the divisor, so its top bit is free.
  always_comb begin
    trial    = {rem[VALUE_BITS-2:0], shreg[VALUE_BITS-1]};
    rem_next = (trial >= dvs) ? (trial - dvs) : trial;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == '0);
      if (start) begin
        busy <= 1'b1;
        cnt  <= LAST_CNT;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shreg <= {shreg[VALUE_BITS-2:0], 1'b0};
      rem   <= rem_next;
    end
  end

  assign status.done = done;
  assign status.zero = (rem == '0);

  `TDPT_ASSERT(a_rem_below_dvs, !busy || (rem < dvs), "partial remainder not below divisor")
  `TDPT_ASSERT_NEXT(a_start_busy, start, busy, "remainder unit not busy after start")

endmodule

// ===== src/tdpt_ctrl.sv =====
// Controller: classifies the value, then steps odd divisors d = 3, 5, ...
// while d*d <= value, running the remainder unit for each.
// Depends on tdpt_pkg, tdpt_rem and assert_macros.svh.
`include "assert_macros.svh"

module tdpt_ctrl import tdpt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] value_u,
  input  logic                  out_free,
  output result_t               res
);

  tdpt_state_t state;
  tdpt_state_t state_next;

  logic [VALUE_BITS-1:0] v;
  logic [VALUE_BITS-1:0] d;
  logic [VALUE_BITS:0]   sq;
  logic                  np_flag;
  logic                  prime_flag;

  logic        rem_start;
  rem_status_t rem_st;

  logic cls_np;
  logic cls_one;
  logic cls_two;
  logic cls_even;
  logic bound_hit;
  logic in_xfer;

  assign in_xfer   = in_valid && in_ready;
  assign cls_np    = v[VALUE_BITS-1] || (v == '0);
  assign cls_one   = (v == VALUE_BITS'(1));
  assign cls_two   = (v == VALUE_BITS'(2));
  assign cls_even  = !v[0];
  assign bound_hit = (sq > {1'b0, v});

  tdpt_rem #(.VALUE_BITS(VALUE_BITS)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (v),
    .divisor  (d),
    .status   (rem_st)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) state_next = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        if (cls_np || cls_one || cls_two || cls_even) state_next = ST_FINISH;
        else state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (bound_hit) state_next = ST_FINISH;
        else state_next = ST_DIV;
      end
      ST_DIV: begin
        if (rem_st.done) begin
          state_next = rem_st.zero ? ST_FINISH : ST_CHECK;
        end
      end
      ST_FINISH: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready         = 1'b0;
    rem_start        = 1'b0;
    res.valid        = 1'b0;
    res.not_positive = np_flag;
    res.is_prime     = prime_flag;
    unique case (state)
      ST_IDLE:   in_ready  = 1'b1;
      ST_CHECK:  rem_start = !bound_hit;
      ST_FINISH: res.valid = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Value, divisor, square of divisor and result flags
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          v  <= value_u;
          d  <= VALUE_BITS'(3);
          sq <= (VALUE_BITS+1)'(9);
        end
      end
      ST_CLASSIFY: begin
        np_flag    <= cls_np;
        prime_flag <= !cls_np && cls_two;
      end
      ST_CHECK: begin
        // No divisor up to the bound divides: prime
        if (bound_hit) prime_flag <= 1'b1;
      end
      ST_DIV: begin
        if (rem_st.done && !rem_st.zero) begin
          // (d+2)^2 = d^2 + 4d + 4
          sq <= sq + ((VALUE_BITS+1)'(d) << 2) + (VALUE_BITS+1)'(4);
          d  <= d + VALUE_BITS'(2);
        end
      end
      default: ;
    endcase
  end

  `TDPT_ASSERT(a_d_odd, (state == ST_IDLE) || (state == ST_CLASSIFY) || d[0], "divisor even")
  `TDPT_ASSERT(a_np_excl, !(res.valid && res.not_positive && res.is_prime), "np with prime")
  `TDPT_ASSERT_NEXT(a_start_div, rem_start, state == ST_DIV, "start without divide state")

endmodule

// ===== src/trial_division_prime_test.sv =====
// Values <= 2, even or not positive are settled by classification alone; otherwise
// the bit-serial remainder unit runs once per odd divisor 3, 5, ... up to
// floor(sqrt(value)), stopping at the first divisor that divides the value.
// Throughput: one item at a time; the next is taken once the result is in
// the output register. Reset (rst, synchronous) returns to idle, output empty.
module trial_division_prime_test import tdpt_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         not_positive,
  output logic                         is_prime
);

  result_t res;
  logic    out_free;

  assign out_free = !out_valid || out_ready;

  tdpt_ctrl #(.VALUE_BITS(VALUE_BITS)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .value_u  ($unsigned(value)),
    .out_free (out_free),
    .res      (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      not_positive <= res.not_positive;
      is_prime     <= res.is_prime;
    end
  end

endmodule
